FILE: rtl/core/calu_pkg.sv
// Package with the request and response types, operation codes and constants of the ALU.
package calu_pkg;

  // Operation codes carried in the action field.
  typedef enum logic [4:0] {
    ACT_ADD   = 5'd0,
    ACT_ADC   = 5'd1,
    ACT_SUB   = 5'd2,
    ACT_SBC   = 5'd3,
    ACT_AND   = 5'd4,
    ACT_XOR   = 5'd5,
    ACT_OR    = 5'd6,
    ACT_CP    = 5'd7,
    ACT_INC8  = 5'd8,
    ACT_DEC8  = 5'd9,
    ACT_ADD16 = 5'd10,
    ACT_INC16 = 5'd11,
    ACT_DEC16 = 5'd12,
    ACT_RLCA  = 5'd13,
    ACT_RLA   = 5'd14,
    ACT_RRCA  = 5'd15,
    ACT_RRA   = 5'd16,
    ACT_DAA   = 5'd17,
    ACT_CPL   = 5'd18,
    ACT_SCF   = 5'd19,
    ACT_CCF   = 5'd20
  } action_e;

  // Constants used by the flag rules and the decimal adjust.
  localparam logic [3:0]  NIB_MAX      = 4'hF;
  localparam logic [3:0]  BCD_DIGIT_MAX = 4'd9;
  localparam logic [7:0]  DAA_LOW_FIX  = 8'h06;
  localparam logic [7:0]  DAA_HIGH_FIX = 8'h60;
  localparam logic [7:0]  DAA_LIMIT    = 8'h99;

  // One ALU request: operation, operands and the current flags.
  typedef struct packed {
    logic [4:0]  action;
    logic [15:0] value_a;
    logic [15:0] value_b;
    logic        zero_in;
    logic        subtract_in;
    logic        half_carry_in;
    logic        carry_in;
  } req_t;

  // One ALU response: value and new flags.
  typedef struct packed {
    logic [15:0] result;
    logic        zero_out;
    logic        subtract_out;
    logic        half_carry_out;
    logic        carry_out;
  } rsp_t;

endpackage

FILE: rtl/core/calu_alu.sv
// Combinational ALU datapath: computes the value and new flags for one request.
module calu_alu (
  input  calu_pkg::req_t req_i,
  output calu_pkg::rsp_t rsp_o
);

  logic [7:0]  a;
  logic [7:0]  b;
  logic        cin;
  logic [8:0]  sum8;
  logic [4:0]  sum_nib;
  logic [8:0]  diff8;
  logic [4:0]  diff_nib;
  logic [16:0] sum16;
  logic [12:0] sum12;
  logic [7:0]  daa_fix;
  logic        daa_low;
  logic        daa_high;
  logic [7:0]  daa_val;

  assign a = req_i.value_a[7:0];
  assign b = req_i.value_b[7:0];

  // Carry or borrow enters only for the with-carry forms.
  assign cin = ((req_i.action == calu_pkg::ACT_ADC) || (req_i.action == calu_pkg::ACT_SBC))
               ? req_i.carry_in : 1'b0;

  // Shared 8-bit adder and subtractor with nibble carries.
  assign sum8     = {1'b0, a} + {1'b0, b} + {8'b0, cin};
  assign sum_nib  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'b0, cin};
  assign diff8    = {1'b0, a} - {1'b0, b} - {8'b0, cin};
  assign diff_nib = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'b0, cin};

  // 16-bit add with the carry out of bit 11.
  assign sum16 = {1'b0, req_i.value_a} + {1'b0, req_i.value_b};
  assign sum12 = {1'b0, req_i.value_a[11:0]} + {1'b0, req_i.value_b[11:0]};

  // Decimal adjust correction.
  assign daa_low  = req_i.half_carry_in ||
                    (!req_i.subtract_in && (a[3:0] > calu_pkg::BCD_DIGIT_MAX));
  assign daa_high = req_i.carry_in || (!req_i.subtract_in && (a > calu_pkg::DAA_LIMIT));
  assign daa_fix  = (daa_low ? calu_pkg::DAA_LOW_FIX : 8'h00) |
                    (daa_high ? calu_pkg::DAA_HIGH_FIX : 8'h00);
  assign daa_val  = req_i.subtract_in ? (a - daa_fix) : (a + daa_fix);

  // Result and flag selection; untouched flags pass through.
  always_comb begin
    rsp_o.result         = req_i.value_a;
    rsp_o.zero_out       = req_i.zero_in;
    rsp_o.subtract_out   = req_i.subtract_in;
    rsp_o.half_carry_out = req_i.half_carry_in;
    rsp_o.carry_out      = req_i.carry_in;
    unique case (req_i.action)
      calu_pkg::ACT_ADD, calu_pkg::ACT_ADC: begin
        rsp_o.result         = {8'h00, sum8[7:0]};
        rsp_o.zero_out       = (sum8[7:0] == 8'h00);
        rsp_o.subtract_out   = 1'b0;
        rsp_o.half_carry_out = sum_nib[4];
        rsp_o.carry_out      = sum8[8];
      end
      calu_pkg::ACT_SUB, calu_pkg::ACT_SBC, calu_pkg::ACT_CP: begin
        rsp_o.result         = (req_i.action == calu_pkg::ACT_CP) ? {8'h00, a}
                                                                   : {8'h00, diff8[7:0]};
        rsp_o.zero_out       = (diff8[7:0] == 8'h00);
        rsp_o.subtract_out   = 1'b1;
        rsp_o.half_carry_out = diff_nib[4];
        rsp_o.carry_out      = diff8[8];
      end
      calu_pkg::ACT_AND: begin
        rsp_o.result         = {8'h00, a & b};
        rsp_o.zero_out       = ((a & b) == 8'h00);
        rsp_o.subtract_out   = 1'b0;
        rsp_o.half_carry_out = 1'b1;
        rsp_o.carry_out      = 1'b0;
      end
      calu_pkg::ACT_XOR: begin
        rsp_o.result         = {8'h00, a ^ b};
        rsp_o.zero_out       = ((a ^ b) == 8'h00);
        rsp_o.subtract_out   = 1'b0;
        rsp_o.half_carry_out = 1'b0;
        rsp_o.carry_out      = 1'b0;
      end
      calu_pkg::ACT_OR: begin
        rsp_o.result         = {8'h00, a | b};
        rsp_o.zero_out       = ((a | b) == 8'h00);
        rsp_o.subtract_out   = 1'b0;
        rsp_o.half_carry_out = 1'b0;
        rsp_o.carry_out      = 1'b0;
      end
      calu_pkg::ACT_INC8: begin
        rsp_o.result         = {8'h00, a + 8'd1};
        rsp_o.zero_out       = (a == 8'hFF);
        rsp_o.subtract_out   = 1'b0;
        rsp_o.half_carry_out = (a[3:0] == calu_pkg::NIB_MAX);
      end
      calu_pkg::ACT_DEC8: begin
        rsp_o.result         = {8'h00, a - 8'd1};
        rsp_o.zero_out       = (a == 8'h01);
        rsp_o.subtract_out   = 1'b1;
        rsp_o.half_carry_out = (a[3:0] == 4'h0);
      end
      calu_pkg::ACT_ADD16: begin
        rsp_o.result         = sum16[15:0];
        rsp_o.subtract_out   = 1'b0;
        rsp_o.half_carry_out = sum12[12];
        rsp_o.carry_out      = sum16[16];
      end
      calu_pkg::ACT_INC16: begin
        rsp_o.result = req_i.value_a + 16'd1;
      end
      calu_pkg::ACT_DEC16: begin
        rsp_o.result = req_i.value_a - 16'd1;
      end
      calu_pkg::ACT_RLCA, calu_pkg::ACT_RLA, calu_pkg::ACT_RRCA, calu_pkg::ACT_RRA: begin
        rsp_o.zero_out       = 1'b0;
        rsp_o.subtract_out   = 1'b0;
        rsp_o.half_carry_out = 1'b0;
        if (req_i.action == calu_pkg::ACT_RLCA) begin
          rsp_o.result    = {8'h00, a[6:0], a[7]};
          rsp_o.carry_out = a[7];
        end else if (req_i.action == calu_pkg::ACT_RLA) begin
          rsp_o.result    = {8'h00, a[6:0], req_i.carry_in};
          rsp_o.carry_out = a[7];
        end else if (req_i.action == calu_pkg::ACT_RRCA) begin
          rsp_o.result    = {8'h00, a[0], a[7:1]};
          rsp_o.carry_out = a[0];
        end else begin
          rsp_o.result    = {8'h00, req_i.carry_in, a[7:1]};
          rsp_o.carry_out = a[0];
        end
      end
      calu_pkg::ACT_DAA: begin
        rsp_o.result         = {8'h00, daa_val};
        rsp_o.zero_out       = (daa_val == 8'h00);
        rsp_o.half_carry_out = 1'b0;
        rsp_o.carry_out      = req_i.carry_in | daa_high;
      end
      calu_pkg::ACT_CPL: begin
        rsp_o.result         = {8'h00, ~a};
        rsp_o.subtract_out   = 1'b1;
        rsp_o.half_carry_out = 1'b1;
      end
      calu_pkg::ACT_SCF: begin
        rsp_o.result         = {8'h00, a};
        rsp_o.subtract_out   = 1'b0;
        rsp_o.half_carry_out = 1'b0;
        rsp_o.carry_out      = 1'b1;
      end
      calu_pkg::ACT_CCF: begin
        rsp_o.result         = {8'h00, a};
        rsp_o.subtract_out   = 1'b0;
        rsp_o.half_carry_out = 1'b0;
        rsp_o.carry_out      = ~req_i.carry_in;
      end
      default: begin
        // Undefined codes return the first operand with flags unchanged.
        rsp_o.result = req_i.value_a;
      end
    endcase
  end

endmodule

FILE: rtl/core/cpu_alu_with_flags_core.sv
// Top level of the flag ALU: input register, ALU datapath and result register.
// Flow: a request accepted into the input register passes through the ALU datapath into the
// result register, which presents its response on the output until it is taken.
// Throughput: one request per cycle; the input stalls only while both registers are full
// and the output is stalled, and the ALU logic between them is a single combinational stage.
// Reset: rst_ni clears both stage valid bits asynchronously; payload registers are not reset.
module cpu_alu_with_flags_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  calu_pkg::req_t in_req_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output calu_pkg::rsp_t out_rsp_o
);

  logic           s1_valid_q;
  logic           s1_valid_d;
  calu_pkg::req_t s1_req_q;
  logic           out_valid_q;
  logic           out_valid_d;
  calu_pkg::rsp_t out_rsp_q;
  calu_pkg::rsp_t alu_rsp;
  logic           out_free;
  logic           s1_free;
  logic           in_take;

  // Stage advance: the result register frees when empty or its response is taken.
  assign out_free = !out_valid_q || !out_stall_i;
  assign s1_free  = !s1_valid_q || out_free;
  assign in_take  = in_valid_i && s1_free;

  assign s1_valid_d  = in_take ? 1'b1 : (out_free ? 1'b0 : s1_valid_q);
  assign out_valid_d = out_free ? s1_valid_q : out_valid_q;

  // Valid bits of both stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers load only when their stage advances.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_req_q <= in_req_i;
    end
    if (out_free && s1_valid_q) begin
      out_rsp_q <= alu_rsp;
    end
  end

  // ALU datapath between the two registers.
  calu_alu u_alu (
    .req_i (s1_req_q),
    .rsp_o (alu_rsp)
  );

  assign in_stall_o  = !s1_free;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

`ifndef ASSERT_OFF
  // The input side stalls only when both stages are full and the output is held.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled without a full pipeline");

  // An accepted request always lands in the input register.
  a_take_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> s1_valid_q)
    else $error("accepted request lost at the input register");

  // A request in the input register moves to the output when the output is free.
  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_free) |=> out_valid_q)
    else $error("request dropped between stages");

  // A held response keeps its payload.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(out_rsp_q)))
    else $error("held response changed");
`endif

endmodule
